>>> design/bli_pkg.sv
package bli_pkg;

    localparam int VALUE_BITS     = 16;
    localparam int FRAC_BITS      = 16;
    localparam int MAX_POINTS_DEF = 64;
    localparam int INDEX_BITS     = 6;
    localparam int POINTS_BITS    = 7;
    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;

    localparam logic [PADDR_BITS-1:0]  ADDR_POINTS  = 3'd0;
    localparam logic [PADDR_BITS-1:0]  ADDR_FIRST   = 3'd4;
    localparam logic [POINTS_BITS-1:0] POINTS_RESET = 7'd2;
    localparam logic [INDEX_BITS-1:0]  FIRST_RESET  = 6'd0;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        OUT_BELOW  = 2'd0,
        OUT_ABOVE  = 2'd1,
        OUT_INTERP = 2'd2,
        OUT_NONE   = 2'd3
    } outcome_t;

    typedef struct packed
    {
        cmd_t                  cmd;
        logic [INDEX_BITS-1:0] entry_index;
        value_t                entry_x;
        value_t                entry_y;
        value_t                query_y;
    } req_t;

    typedef struct packed
    {
        value_t                x_value;
        outcome_t              outcome;
        logic [INDEX_BITS-1:0] segment_index;
    } rsp_t;

    typedef enum logic [1:0]
    {
        RD_ZERO = 2'd0,
        RD_LAST = 2'd1,
        RD_PTR  = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0]
    {
        RES_RD     = 2'd0,
        RES_PREV   = 2'd1,
        RES_INTERP = 2'd2
    } res_sel_t;

    typedef struct packed
    {
        logic     query_take;
        rd_sel_t  rd_sel;
        logic     ptr_inc;
        logic     prev_we;
        logic     seg_take;
        logic     div_step;
        logic     mul_we;
        logic     res_we;
        res_sel_t res_sel;
        outcome_t res_outcome;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic query_go;
        logic below;
        logic above;
        logic no_scan;
        logic match;
        logic span_zero;
        logic last_seg;
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

>>> design/bli_ram.sv
module bli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bli_ctrl.sv
module bli_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bli_pkg::ctrl_status_t status,
    output bli_pkg::ctrl_cmd_t    cmd,
    output logic                  busy
);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_CHK_LAST,
        ST_PRIME,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = bli_pkg::RD_PTR;
        cmd.res_sel     = bli_pkg::RES_RD;
        cmd.res_outcome = bli_pkg::OUT_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.query_go)
                begin
                    cmd.query_take = 1'b1;
                    state_next     = ST_RD_FIRST;
                end
            end
            ST_RD_FIRST:
            begin
                cmd.rd_sel = bli_pkg::RD_ZERO;
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                cmd.rd_sel = bli_pkg::RD_LAST;
                if (status.below)
                begin
                    cmd.res_we      = 1'b1;
                    cmd.res_outcome = bli_pkg::OUT_BELOW;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST:
            begin
                cmd.ptr_inc     = 1'b1;
                cmd.res_we      = 1'b1;
                cmd.res_outcome = status.above ? bli_pkg::OUT_ABOVE : bli_pkg::OUT_NONE;
                if (status.above || status.no_scan)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                cmd.ptr_inc = 1'b1;
                cmd.prev_we = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.ptr_inc = 1'b1;
                cmd.prev_we = 1'b1;
                if (status.match)
                begin
                    cmd.seg_take = 1'b1;
                    if (status.span_zero)
                    begin
                        cmd.res_we      = 1'b1;
                        cmd.res_sel     = bli_pkg::RES_PREV;
                        cmd.res_outcome = bli_pkg::OUT_INTERP;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
                else if (status.last_seg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_we = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.res_we      = 1'b1;
                cmd.res_sel     = bli_pkg::RES_INTERP;
                cmd.res_outcome = bli_pkg::OUT_INTERP;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register still occupied");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && status.match && !status.span_zero |=> state_reg == ST_DIV)
        else $error("matching segment did not start the divider");

endmodule

>>> design/bli_dp.sv
module bli_dp #(
    parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  bli_pkg::req_t                      req,
    input  logic [bli_pkg::POINTS_BITS-1:0]    points_in_use,
    input  logic [bli_pkg::INDEX_BITS-1:0]     first_segment,
    input  bli_pkg::ctrl_cmd_t                 cmd,
    output bli_pkg::ctrl_status_t              status,
    input  logic                               rsp_stall,
    output logic                               rsp_valid,
    output bli_pkg::rsp_t                      rsp
);

    localparam int VB   = bli_pkg::VALUE_BITS;
    localparam int FB   = bli_pkg::FRAC_BITS;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int NW   = AW + 1;
    localparam int CW0  = (NW > bli_pkg::POINTS_BITS) ? NW : bli_pkg::POINTS_BITS;
    localparam int CW   = (CW0 > bli_pkg::INDEX_BITS + 1) ? CW0 : bli_pkg::INDEX_BITS + 1;
    localparam int PW   = VB + FB + 3;
    localparam int DW   = 2 * VB;
    localparam int CNTW = $clog2(FB + 1);

    logic [CW-1:0] pu_w;
    logic [CW-1:0] fs_w;
    logic [CW-1:0] idx_w;
    logic [CW-1:0] n_clamp;
    logic          load_we;

    logic [AW-1:0] raddr;
    logic [DW-1:0] rd_data;
    bli_pkg::value_t rd_x;
    bli_pkg::value_t rd_y;

    bli_pkg::value_t q_reg;
    logic [NW-1:0]   n_reg;
    logic            no_scan_reg;
    logic [NW-1:0]   ptr_reg;
    bli_pkg::value_t prev_x_reg;
    bli_pkg::value_t prev_y_reg;
    logic [bli_pkg::INDEX_BITS-1:0] seg_reg;

    logic [NW-1:0]   cur;
    logic [CW-1:0]   cur_w;
    logic [NW-1:0]   last_idx;

    logic signed [VB:0] num_s;
    logic signed [VB:0] span_s;
    logic signed [VB:0] dx_s;

    bli_pkg::value_t    xl_reg;
    logic signed [VB:0] dx_reg;
    logic [VB-1:0]      d_reg;
    logic [VB:0]        rem_reg;
    logic [VB:0]        rem_next;
    logic [VB:0]        rem_diff;
    logic               rem_ge;
    logic [FB:0]        quo_reg;
    logic [CNTW-1:0]    cnt_reg;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] shifted;
    logic [VB-1:0]        interp_x;

    bli_pkg::value_t   res_x_reg;
    bli_pkg::value_t   res_x_next;
    bli_pkg::outcome_t res_outcome_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    bli_pkg::rsp_t rsp_reg;

    always_comb
    begin
        pu_w  = CW'(points_in_use);
        fs_w  = CW'(first_segment);
        idx_w = CW'(req.entry_index);
        if (pu_w < CW'(2))
        begin
            n_clamp = CW'(2);
        end
        else if (pu_w > CW'(MAX_POINTS))
        begin
            n_clamp = CW'(MAX_POINTS);
        end
        else
        begin
            n_clamp = pu_w;
        end
    end

    assign load_we = accept && (req.cmd == bli_pkg::CMD_LOAD) && (idx_w < CW'(MAX_POINTS));

    always_comb
    begin
        unique case (cmd.rd_sel)
            bli_pkg::RD_ZERO: raddr = '0;
            bli_pkg::RD_LAST: raddr = last_idx[AW-1:0];
            bli_pkg::RD_PTR:  raddr = ptr_reg[AW-1:0];
            default:          raddr = ptr_reg[AW-1:0];
        endcase
    end

    bli_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (idx_w[AW-1:0]),
        .wdata ({req.entry_x, req.entry_y}),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign rd_x     = $signed(rd_data[DW-1:VB]);
    assign rd_y     = $signed(rd_data[VB-1:0]);
    assign cur      = ptr_reg - NW'(1);
    assign cur_w    = CW'(cur);
    assign last_idx = n_reg - NW'(1);

    assign num_s  = {q_reg[VB-1], q_reg} - {prev_y_reg[VB-1], prev_y_reg};
    assign span_s = {rd_y[VB-1], rd_y} - {prev_y_reg[VB-1], prev_y_reg};
    assign dx_s   = {rd_x[VB-1], rd_x} - {prev_x_reg[VB-1], prev_x_reg};

    assign rem_ge   = rem_reg >= {1'b0, d_reg};
    assign rem_diff = rem_ge ? (rem_reg - {1'b0, d_reg}) : rem_reg;
    assign rem_next = {rem_diff[VB-1:0], 1'b0};

    assign rnd      = prod_reg + PW'(2 ** (FB - 1));
    assign shifted  = rnd >>> FB;
    assign interp_x = xl_reg + shifted[VB-1:0];

    always_comb
    begin
        case (cmd.res_sel)
            bli_pkg::RES_PREV:   res_x_next = prev_x_reg;
            bli_pkg::RES_INTERP: res_x_next = $signed(interp_x);
            default:             res_x_next = rd_x;
        endcase
    end

    always_comb
    begin
        status.query_go  = accept && (req.cmd == bli_pkg::CMD_QUERY);
        status.below     = q_reg < rd_y;
        status.above     = q_reg > rd_y;
        status.no_scan   = no_scan_reg;
        status.match     = (q_reg >= prev_y_reg) && (q_reg <= rd_y);
        status.span_zero = (rd_y == prev_y_reg);
        status.last_seg  = (cur == last_idx);
        status.div_done  = (cnt_reg == CNTW'(FB));
        status.out_free  = !out_valid_reg || !rsp_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_take)
        begin
            q_reg       <= req.query_y;
            n_reg       <= n_clamp[NW-1:0];
            no_scan_reg <= (fs_w + CW'(1)) >= n_clamp;
            ptr_reg     <= fs_w[NW-1:0];
            seg_reg     <= '0;
        end
        else
        begin
            if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + NW'(1);
            end
            if (cmd.seg_take)
            begin
                seg_reg <= cur_w[bli_pkg::INDEX_BITS-1:0];
            end
        end
        if (cmd.prev_we)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (cmd.seg_take)
        begin
            xl_reg  <= prev_x_reg;
            dx_reg  <= dx_s;
            d_reg   <= span_s[VB-1:0];
            rem_reg <= {1'b0, num_s[VB-1:0]};
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FB-1:0], rem_ge};
            cnt_reg <= cnt_reg + CNTW'(1);
        end
        if (cmd.mul_we)
        begin
            prod_reg <= dx_reg * $signed({1'b0, quo_reg});
        end
        if (cmd.res_we)
        begin
            res_x_reg       <= res_x_next;
            res_outcome_reg <= cmd.res_outcome;
        end
        if (cmd.out_load)
        begin
            rsp_reg.x_value       <= res_x_reg;
            rsp_reg.outcome       <= res_outcome_reg;
            rsp_reg.segment_index <= seg_reg;
        end
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> cnt_reg <= CNTW'(FB))
        else $error("divider stepped past its last quotient bit");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_we && (cmd.res_sel == bli_pkg::RES_INTERP) |-> quo_reg <= {1'b1, {FB{1'b0}}})
        else $error("interpolation fraction above one");

endmodule

>>> design/breakpoint_linear_interpolator.sv
// Load transaction: one per cycle when idle, written to the breakpoint table in the cycle taken.
// Query transaction: result registered after the entry-0 read when clamped below, after the
// last-entry read when clamped above or no scan, else after k segments scanned (at most 63
// at the default depth), one per cycle through the table read port, then 17 divider steps.
// One query in flight at a time; the next is taken after the result enters the output register.
// Reset clears control state, points_in_use to 2, first_segment to 0; table undefined.
module breakpoint_linear_interpolator #(
    parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bli_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [bli_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [bli_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  bli_pkg::req_t                   req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output bli_pkg::rsp_t                   rsp
);

    logic [bli_pkg::POINTS_BITS-1:0] points_in_use_reg;
    logic [bli_pkg::INDEX_BITS-1:0]  first_segment_reg;
    logic                            cfg_we;
    logic                            accept;
    logic                            busy;
    bli_pkg::ctrl_cmd_t              cmd;
    bli_pkg::ctrl_status_t           status;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= bli_pkg::POINTS_RESET;
            first_segment_reg <= bli_pkg::FIRST_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr == bli_pkg::ADDR_POINTS)
            begin
                points_in_use_reg <= pwdata[bli_pkg::POINTS_BITS-1:0];
            end
            if (paddr == bli_pkg::ADDR_FIRST)
            begin
                first_segment_reg <= pwdata[bli_pkg::INDEX_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr)
            bli_pkg::ADDR_POINTS: prdata = bli_pkg::PDATA_BITS'(points_in_use_reg);
            bli_pkg::ADDR_FIRST:  prdata = bli_pkg::PDATA_BITS'(first_segment_reg);
            default:              prdata = '0;
        endcase
    end

    assign req_stall = busy;
    assign accept    = req_valid && !busy;

    bli_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bli_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req           (req),
        .points_in_use (points_in_use_reg),
        .first_segment (first_segment_reg),
        .cmd           (cmd),
        .status        (status),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .rsp           (rsp)
    );

endmodule
